### rtl/word_substring_match_counter_defines.svh
// ----------------------------------------------------------------------------
// word_substring_match_counter_defines
// assertion macros shared by the modules of the word match counter
// ----------------------------------------------------------------------------
`ifndef WORD_SUBSTRING_MATCH_COUNTER_DEFINES_SVH
`define WORD_SUBSTRING_MATCH_COUNTER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define WSMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsmc assertion failed");

// consequent holds in the cycle after the antecedent
`define WSMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsmc assertion failed");

`endif

### rtl/wsmc_pkg.sv
// ----------------------------------------------------------------------------
// wsmc_pkg
// types, constants and the byte classifier of the word match counter
// ----------------------------------------------------------------------------
package wsmc_pkg;

   localparam int MaxPattern   = 8;
   localparam int WindowBits   = 8 * MaxPattern;
   localparam int CsrIndexBits = 2;
   localparam int QueueDepth   = 2;

   localparam logic [CsrIndexBits-1:0] CsrPatternBytes  = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CsrPatternLength = CsrIndexBits'(1);

   localparam logic [7:0] Hyphen = 8'h2d;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_word;
      logic       last;
   } item_type;

   // hand-off between front queue and back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   function automatic logic is_word_byte(input logic [7:0] b);
      logic digit;
      logic upper;
      logic lower;
      digit = (b >= 8'h30) && (b <= 8'h39);
      upper = (b >= 8'h41) && (b <= 8'h5a);
      lower = (b >= 8'h61) && (b <= 8'h7a);
      return digit || upper || lower || (b == Hyphen);
   endfunction

endpackage

### rtl/wsmc_front.sv
// ----------------------------------------------------------------------------
// wsmc_front
// accepts text bytes, classifies them and holds them in a two entry queue
// ----------------------------------------------------------------------------
`include "word_substring_match_counter_defines.svh"

module wsmc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [7:0]              req_text_byte,
   input  logic                    req_end_of_text,
   output wsmc_pkg::queue_head_type head,
   input  logic                    head_take
);

   localparam int PtrBits = $clog2(wsmc_pkg::QueueDepth);

   wsmc_pkg::item_type entry_ff [wsmc_pkg::QueueDepth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   count_ff, count_in;
   logic               push_acc;
   logic               take_acc;

   assign req_full = (count_ff == (PtrBits+1)'(wsmc_pkg::QueueDepth));
   assign push_acc = req_push && !req_full;
   assign take_acc = head_take && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_acc) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(wsmc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take_acc) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(wsmc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_acc, take_acc})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         entry_ff[wr_ptr_ff].text_byte <= req_text_byte;
         entry_ff[wr_ptr_ff].is_word   <= wsmc_pkg::is_word_byte(req_text_byte);
         entry_ff[wr_ptr_ff].last      <= req_end_of_text;
      end
   end

   `WSMC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= (PtrBits+1)'(wsmc_pkg::QueueDepth))
   `WSMC_ASSERT_NEXT(a_count_up, clock, reset, push_acc && !take_acc,
      count_ff == $past(count_ff) + 1'b1)
   `WSMC_ASSERT_NEXT(a_count_down, clock, reset, take_acc && !push_acc,
      count_ff == $past(count_ff) - 1'b1)

endmodule

### rtl/wsmc_back.sv
// ----------------------------------------------------------------------------
// wsmc_back
// window compare, word tracking, match total and result register
// ----------------------------------------------------------------------------
`include "word_substring_match_counter_defines.svh"

module wsmc_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wsmc_pkg::queue_head_type              head,
   output logic                                  head_take,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wsmc_pkg::CsrIndexBits-1:0]     csr_index,
   input  logic [63:0]                           csr_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [31:0]                           rsp_match_total
);

   localparam int Wb = wsmc_pkg::WindowBits;

   logic [63:0]   pattern_ff;
   logic [3:0]    pattern_len_ff;
   logic [Wb-1:0] window_ff, window_in;
   logic [3:0]    word_len_ff, word_len_in;
   logic          inside_ff, inside_in;
   logic          found_ff, found_in;
   logic [31:0]   total_ff, total_in;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_total_ff;

   logic [Wb-1:0] window_new;
   logic [3:0]    word_len_new;
   logic [3:0]    len_clamp;
   logic          lane_hit;
   logic          match;
   logic          bump;
   logic [31:0]   total_bumped;

   assign csr_ready       = 1'b1;
   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_match_total = rsp_total_ff;

   // a last byte needs the result register free, or freed this cycle
   assign head_take = head.valid && (!head.item.last || !rsp_valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         pattern_len_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wsmc_pkg::CsrPatternBytes:  pattern_ff     <= csr_data;
            wsmc_pkg::CsrPatternLength: pattern_len_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // newest pattern_length window bytes against the pattern
   always_comb begin
      window_new   = Wb'({window_ff, head.item.text_byte});
      word_len_new = (word_len_ff == 4'hf) ? word_len_ff : word_len_ff + 1'b1;
      len_clamp    = (pattern_len_ff > 4'(wsmc_pkg::MaxPattern)) ?
                     4'(wsmc_pkg::MaxPattern) : pattern_len_ff;
      match        = 1'b0;
      lane_hit     = 1'b0;
      for (int l = 0; l <= wsmc_pkg::MaxPattern; l++) begin
         lane_hit = (word_len_new >= 4'(l));
         for (int i = 0; i < l; i++) begin
            lane_hit = lane_hit &&
                       (pattern_ff[8*i +: 8] == window_new[8*(l-1-i) +: 8]);
         end
         if (len_clamp == 4'(l)) begin
            match = lane_hit;
         end
      end
   end

   always_comb begin
      // at most one word closes per byte
      if (head.item.is_word) begin
         bump = head.item.last && (found_ff || match);
      end else begin
         bump = inside_ff && found_ff;
      end
      bump         = bump && (total_ff != '1);
      total_bumped = bump ? total_ff + 1'b1 : total_ff;

      window_in   = window_ff;
      word_len_in = word_len_ff;
      inside_in   = inside_ff;
      found_in    = found_ff;
      total_in    = total_ff;
      if (head_take) begin
         priority if (head.item.last) begin
            window_in   = '0;
            word_len_in = '0;
            inside_in   = 1'b0;
            found_in    = 1'b0;
            total_in    = '0;
         end else if (head.item.is_word) begin
            window_in   = window_new;
            word_len_in = word_len_new;
            inside_in   = 1'b1;
            found_in    = found_ff || match;
         end else begin
            window_in   = '0;
            word_len_in = '0;
            inside_in   = 1'b0;
            found_in    = 1'b0;
            total_in    = total_bumped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         word_len_ff  <= '0;
         inside_ff    <= 1'b0;
         found_ff     <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff   <= window_in;
         word_len_ff <= word_len_in;
         inside_ff   <= inside_in;
         found_ff    <= found_in;
         total_ff    <= total_in;
         if (head_take && head.item.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_take && head.item.last) begin
         rsp_total_ff <= total_bumped;
      end
   end

   `WSMC_ASSERT_NEXT(a_last_gives_result, clock, reset, head_take && head.item.last,
      rsp_valid_ff && !inside_ff && (total_ff == '0))
   `WSMC_ASSERT_NEXT(a_total_monotonic, clock, reset, !(head_take && head.item.last),
      total_ff >= $past(total_ff))
   `WSMC_ASSERT_NOW(a_found_needs_word, clock, reset, found_ff, inside_ff)

endmodule

### rtl/word_substring_match_counter.sv
// ----------------------------------------------------------------------------
// word_substring_match_counter
// counts the words of a byte stream that contain a configured pattern
// ----------------------------------------------------------------------------
//   channel   direction   handshake            payload
//   req_      in          push / full          text_byte, end_of_text
//   rsp_      out         pop / empty          match_total
//   csr_      in          valid / ready        index, data
//
// one byte per cycle unless a last byte waits on an unpopped result; a result shows
// on rsp_ once its last byte has passed the front queue and the result register
// reset is synchronous and clears queue, word state, total and pattern registers
// full rises only when a last byte waits in the queue behind an unpopped result
// csr_ready is always high
// ----------------------------------------------------------------------------
module word_substring_match_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_end_of_text,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [31:0]                       rsp_match_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wsmc_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [63:0]                       csr_data
);

   wsmc_pkg::queue_head_type head;
   logic                     head_take;

   wsmc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .head            (head),
      .head_take       (head_take)
   );

   wsmc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_take       (head_take),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_match_total (rsp_match_total)
   );

endmodule

### verif/word_substring_match_counter_tb.sv
// ----------------------------------------------------------------------------
// word_substring_match_counter_tb
// drives byte streams into the word match counter and checks every total
// against a cycle-free shadow of the word and pattern state. directed tests
// cover the character class edges, the empty pattern, an oversized pattern
// length and a pattern that holds a separator; random texts then mix words
// that carry the pattern, near misses and noise under random pattern settings,
// with random gaps on the push side and random stalls on the pop side.
// ----------------------------------------------------------------------------
module word_substring_match_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_push        = 1'b0;
   logic                              req_full;
   logic [7:0]                        req_text_byte   = 8'h00;
   logic                              req_end_of_text = 1'b0;
   logic                              rsp_empty;
   logic                              rsp_pop         = 1'b0;
   logic [31:0]                       rsp_match_total;
   logic                              csr_valid       = 1'b0;
   logic                              csr_ready;
   logic [wsmc_pkg::CsrIndexBits-1:0] csr_index       = wsmc_pkg::CsrPatternBytes;
   logic [63:0]                       csr_data        = 64'h0;

   // shadow of the block: word state, total and pattern registers
   logic [wsmc_pkg::WindowBits-1:0] shadow_window;
   logic [3:0]              shadow_word_len;
   logic                    shadow_in_word;
   logic                    shadow_found;
   logic [31:0]             shadow_total;
   logic [63:0]             shadow_pattern;
   logic [3:0]              shadow_pattern_len;

   logic [31:0]             expected_totals[$];
   int                      error_count = 0;
   int                      bytes_sent  = 0;
   bit                      no_idle     = 1'b0;

   word_substring_match_counter uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_match_total (rsp_match_total),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit is_text_char(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
             (b >= 8'h61 && b <= 8'h7a) || b == wsmc_pkg::Hyphen;
   endfunction

   function automatic int active_pattern_len();
      return (shadow_pattern_len > wsmc_pkg::MaxPattern) ?
             wsmc_pkg::MaxPattern : int'(shadow_pattern_len);
   endfunction

   function automatic bit window_holds_pattern();
      int len;
      int i;
      len = active_pattern_len();
      if (shadow_word_len < len) return 1'b0;
      for (i = 0; i < len; i++) begin
         // oldest of the newest len window bytes lines up with pattern byte 0
         if (shadow_pattern[8*i +: 8] != shadow_window[8*(len-1-i) +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void close_word();
      if (shadow_in_word && shadow_found && shadow_total != 32'hffff_ffff)
         shadow_total++;
      shadow_window   = '0;
      shadow_word_len = 4'd0;
      shadow_in_word  = 1'b0;
      shadow_found    = 1'b0;
   endfunction

   function automatic void predict_match_total(input logic [7:0] b, input logic last);
      if (is_text_char(b)) begin
         shadow_window = {shadow_window[wsmc_pkg::WindowBits-9:0], b};
         if (shadow_word_len != 4'hf) shadow_word_len++;
         shadow_in_word = 1'b1;
         if (window_holds_pattern()) shadow_found = 1'b1;
      end else begin
         close_word();
      end
      if (last) begin
         close_word();
         expected_totals = {expected_totals, shadow_total};
         shadow_total = 32'd0;
      end
   endfunction

   function automatic logic [7:0] random_word_char();
      int unsigned k;
      k = $urandom_range(0, 62);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 36) return 8'(8'h41 + k - 10);
      if (k < 62) return 8'(8'h61 + k - 36);
      return wsmc_pkg::Hyphen;
   endfunction

   function automatic logic [7:0] random_separator();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_text_char(b));
      return b;
   endfunction

   // character drawn from the current pattern so accidental matches happen
   function automatic logic [7:0] pattern_flavored_char();
      int len;
      len = active_pattern_len();
      if (len == 0 || $urandom_range(0, 3) == 0) return random_word_char();
      return shadow_pattern[8*$urandom_range(0, len-1) +: 8];
   endfunction

   function automatic logic [63:0] pack_pattern(input string s);
      logic [63:0] p;
      int i;
      p = '0;
      for (i = 0; i < s.len() && i < 8; i++) p[8*i +: 8] = s[i];
      return p;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
         @(negedge clock);
         req_push      <= 1'b0;
         req_text_byte <= 8'($urandom);
      end
      @(negedge clock);
      req_push        <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (req_full);
      predict_match_total(b, last);
      bytes_sent++;
   endtask

   task automatic send_string(input string s, input bit close);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
   endtask

   task automatic send_text(input logic [7:0] text[$]);
      int i;
      for (i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
   endtask

   // stop pushing until every total is back, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [wsmc_pkg::CsrIndexBits-1:0] idx,
                            input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == wsmc_pkg::CsrPatternBytes)
         shadow_pattern = data;
      else if (idx == wsmc_pkg::CsrPatternLength)
         shadow_pattern_len = data[3:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // pop side: random stall per transaction, compare against the oldest total
   initial begin : result_checker
      int          stall;
      logic [31:0] want;
      wait (!reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         repeat (stall) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (expected_totals.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual match_total %0d",
                     $time, rsp_match_total);
            error_count++;
         end else begin
            want = expected_totals.pop_front();
            if (rsp_match_total !== want) begin
               $display("%0t: match_total mismatch, expected %0d, actual %0d",
                        $time, want, rsp_match_total);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_pattern();
      // reset pattern is empty, so every word counts
      send_byte("a", 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte("9", 1'b1);
      // separator alone closes no word
      send_byte(8'hff, 1'b1);
   endtask

   task automatic test_class_boundaries();
      send_string("/0:@AZ[", 1'b0);
      send_byte(8'h60, 1'b0);
      send_string("az{-", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b1);
   endtask

   task automatic test_oversized_length();
      drain_results();
      write_csr(wsmc_pkg::CsrPatternBytes, pack_pattern("ab-9XYz0"));
      // length field 15 clamps to a full eight byte window
      write_csr(wsmc_pkg::CsrPatternLength, 64'hffff_ffff_ffff_ffff);
      send_string("ab-9XYz0", 1'b1);
   endtask

   task automatic test_separator_in_pattern();
      drain_results();
      write_csr(wsmc_pkg::CsrPatternBytes, pack_pattern("a b"));
      write_csr(wsmc_pkg::CsrPatternLength, 64'd3);
      send_string("a b", 1'b1);
   endtask

   task automatic send_random_text();
      logic [7:0] text[$];
      int         n_words;
      int         w;
      int         j;
      int         len;
      int         skip;
      logic [7:0] sub;
      len     = active_pattern_len();
      n_words = $urandom_range(0, 6);
      for (w = 0; w < n_words; w++) begin
         if (w > 0 || $urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 3)) text = {text, random_separator()};
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               repeat ($urandom_range(0, 4)) text = {text, pattern_flavored_char()};
               for (j = 0; j < len; j++) text = {text, shadow_pattern[8*j +: 8]};
               repeat ($urandom_range(0, 4)) text = {text, pattern_flavored_char()};
               if (len == 0) text = {text, random_word_char()};
            end
            4, 5: begin
               // near miss: one pattern byte swapped or the tail cut off
               skip = (len == 0) ? -1 : $urandom_range(0, len - 1);
               sub  = random_word_char();
               if ($urandom_range(0, 1) == 0) begin
                  for (j = 0; j < len - 1; j++) text = {text, shadow_pattern[8*j +: 8]};
               end else begin
                  for (j = 0; j < len; j++)
                     text = {text, (j == skip) ? sub : shadow_pattern[8*j +: 8]};
               end
               text = {text, pattern_flavored_char()};
            end
            6, 7: repeat ($urandom_range(1, 18)) text = {text, pattern_flavored_char()};
            8:    repeat ($urandom_range(1, 18)) text = {text, random_word_char()};
            default: repeat ($urandom_range(1, 6)) text = {text, 8'($urandom)};
         endcase
      end
      if ($urandom_range(0, 2) == 0 || text.size() == 0)
         text = {text, $urandom_range(0, 1) ? random_separator() : 8'($urandom)};
      send_text(text);
   endtask

   task automatic test_random_texts();
      int          phase;
      int          phase_end;
      int          start;
      int          len_pick;
      int          k;
      logic [63:0] pattern;
      logic [63:0] len_data;
      bit          paused;
      start  = bytes_sent;
      paused = 1'b0;
      for (phase = 0; phase < 12; phase++) begin
         drain_results();
         len_pick = $urandom_range(0, 9);
         len_data = {$urandom, $urandom};
         len_data[3:0] = (len_pick == 9) ? 4'($urandom_range(9, 15)) : 4'(len_pick);
         pattern = '0;
         for (k = 0; k < 8; k++) pattern[8*k +: 8] = random_word_char();
         case ($urandom_range(0, 5))
            0: pattern = {$urandom, $urandom};
            1: pattern[8*$urandom_range(0, 7) +: 8] = random_separator();
            default: ;
         endcase
         if (phase == 0) begin
            pattern  = 64'h0;
            len_data = 64'h0;
         end else if (phase == 1) begin
            pattern  = 64'hffff_ffff_ffff_ffff;
            len_data = 64'd8;
         end
         write_csr(wsmc_pkg::CsrPatternBytes, pattern);
         write_csr(wsmc_pkg::CsrPatternLength, len_data);
         phase_end = start + (phase + 1) * 1400 / 12;
         while (bytes_sent < phase_end) begin
            no_idle = ($urandom_range(0, 3) == 0);
            send_random_text();
            if (!paused || $urandom_range(0, 7) == 0) begin
               // hold the sender until every pending total has come back
               paused = 1'b1;
               @(negedge clock);
               req_push <= 1'b0;
               while (expected_totals.size() != 0) @(posedge clock);
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      shadow_window      = '0;
      shadow_word_len    = 4'd0;
      shadow_in_word     = 1'b0;
      shadow_found       = 1'b0;
      shadow_total       = 32'd0;
      shadow_pattern     = 64'h0;
      shadow_pattern_len = 4'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_class_boundaries();
      test_oversized_length();
      test_separator_in_pattern();
      test_random_texts();
      drain_results();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### word_substring_match_counter.f
+incdir+rtl
rtl/wsmc_pkg.sv
rtl/wsmc_front.sv
rtl/wsmc_back.sv
rtl/word_substring_match_counter.sv
verif/word_substring_match_counter_tb.sv
